// ----- sv/pcm_pkg.sv -----
package pcm_pkg;

  typedef logic [14:0] color_t;
  typedef logic [4:0]  chan_t;

  localparam chan_t CH_MAX = 5'h1F;

  // Configuration register indexes
  localparam logic [2:0] CFG_BACKDROP_A = 3'd0;
  localparam logic [2:0] CFG_BACKDROP_B = 3'd1;
  localparam logic [2:0] CFG_ENABLE_A   = 3'd2;
  localparam logic [2:0] CFG_ENABLE_B   = 3'd3;
  localparam logic [2:0] CFG_FORCE_B    = 3'd4;
  localparam logic [2:0] CFG_SUBTRACT   = 3'd5;
  localparam logic [2:0] CFG_MODE       = 3'd6;

  // Display modes
  localparam logic [1:0] MODE_BLEND    = 2'd0;
  localparam logic [1:0] MODE_HALF     = 2'd1;
  localparam logic [1:0] MODE_B_OVER_A = 2'd2;
  localparam logic [1:0] MODE_A_OVER_B = 2'd3;

  // Input command codes
  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  // Blend one 5-bit channel, clamped to 0..31
  function automatic chan_t mix_channel(chan_t a, chan_t b, logic sub, logic halve);
    logic [5:0] d;
    logic [5:0] s;
    chan_t      r;
    d = {1'b0, a} - {1'b0, b};
    s = {1'b0, a} + {1'b0, b};
    if (sub) begin
      if (d[5]) begin
        r = 5'd0;
      end else if (halve) begin
        r = {1'b0, d[4:1]};
      end else begin
        r = d[4:0];
      end
    end else begin
      if (halve) begin
        r = s[5:1];
      end else if (s[5]) begin
        r = CH_MAX;
      end else begin
        r = s[4:0];
      end
    end
    return r;
  endfunction

  // 15-bit colour to RGB565, green's top bit copied into the spare bit
  function automatic logic [15:0] encode565(color_t c);
    return {c[14:10], c[9:5], c[9], c[4:0]};
  endfunction

endpackage

// ----- sv/pcm_palette.sv -----
module pcm_palette #(
  parameter int ENTRIES = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [7:0]      wr_addr,
  input  pcm_pkg::color_t wr_data,
  input  logic            rd_en,
  input  logic [7:0]      rd_addr_a,
  input  logic [7:0]      rd_addr_b,
  output pcm_pkg::color_t rd_data_a,
  output pcm_pkg::color_t rd_data_b
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [8:0] ENT_LIMIT = 9'(ENTRIES);

  pcm_pkg::color_t     mem [ENTRIES];
  logic [ENTRIES-1:0]  vld_r;
  pcm_pkg::color_t     q_a_r;
  pcm_pkg::color_t     q_b_r;
  logic                hit_a_r;
  logic                hit_b_r;
  logic                wr_in_range;
  logic                rd_in_range_a;
  logic                rd_in_range_b;

  assign wr_in_range   = {1'b0, wr_addr}   < ENT_LIMIT;
  assign rd_in_range_a = {1'b0, rd_addr_a} < ENT_LIMIT;
  assign rd_in_range_b = {1'b0, rd_addr_b} < ENT_LIMIT;

  // Entry valid bits: clear all at reset, an unwritten entry reads black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en && wr_in_range) begin
      vld_r[wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a_r   <= mem[rd_addr_a[AW-1:0]];
      q_b_r   <= mem[rd_addr_b[AW-1:0]];
      hit_a_r <= rd_in_range_a && vld_r[rd_addr_a[AW-1:0]];
      hit_b_r <= rd_in_range_b && vld_r[rd_addr_b[AW-1:0]];
    end
  end

  assign rd_data_a = hit_a_r ? q_a_r : '0;
  assign rd_data_b = hit_b_r ? q_b_r : '0;

endmodule

// ----- sv/palette_color_math_compositor_unit.sv -----
// Path: an accepted pixel transaction passes the palette read, colour select and
// blend and RGB565 encode registers in that order before it is presented on out_*.
// Throughput: one transaction per cycle when out_stall does not hold the output;
// three register stages (palette read, colour select, blend and RGB565 encode),
// each holding under stall. Palette writes produce no result.
// Reset (rst_n, synchronous): empties the pipeline, restores the registers and
// clears every palette valid bit, so the palette reads black.
module palette_color_math_compositor_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_index_a,
  input  logic [7:0]  in_index_b,
  input  logic [7:0]  in_palette_addr,
  input  logic [14:0] in_palette_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_rgb565,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  pcm_pkg::color_t backdrop_a_r;
  pcm_pkg::color_t backdrop_b_r;
  logic            enable_a_r;
  logic            enable_b_r;
  logic            force_b_r;
  logic            subtract_r;
  logic [1:0]      mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backdrop_a_r <= '0;
      backdrop_b_r <= '0;
      enable_a_r   <= 1'b1;
      enable_b_r   <= 1'b1;
      force_b_r    <= 1'b0;
      subtract_r   <= 1'b0;
      mode_r       <= pcm_pkg::MODE_BLEND;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pcm_pkg::CFG_BACKDROP_A: backdrop_a_r <= cfg_data;
        pcm_pkg::CFG_BACKDROP_B: backdrop_b_r <= cfg_data;
        pcm_pkg::CFG_ENABLE_A:   enable_a_r   <= cfg_data[0];
        pcm_pkg::CFG_ENABLE_B:   enable_b_r   <= cfg_data[0];
        pcm_pkg::CFG_FORCE_B:    force_b_r    <= cfg_data[0];
        pcm_pkg::CFG_SUBTRACT:   subtract_r   <= cfg_data[0];
        pcm_pkg::CFG_MODE:       mode_r       <= cfg_data[1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage advances when empty or when the stage
  // after it advances, so bubbles squeeze out and the input stalls only when
  // every stage is full and the result is held.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_adv, s2_adv, s3_adv;
  logic in_accept;
  logic pix_accept;
  logic wr_accept;

  assign s3_adv   = !s3_v_r || !out_stall;
  assign s2_adv   = !s2_v_r || s3_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;

  assign in_accept  = in_valid && !in_stall;
  assign pix_accept = in_accept && (in_cmd == pcm_pkg::CMD_PIXEL);
  assign wr_accept  = in_accept && (in_cmd == pcm_pkg::CMD_PAL_WRITE);

  // ---------------------------------------------------------------------------
  // Stage 1: palette lookup. A write lands at its accept edge, so any later
  // pixel reads the new colour without forwarding.
  // ---------------------------------------------------------------------------
  pcm_pkg::color_t pal_a;
  pcm_pkg::color_t pal_b;
  logic            s1_nz_a_r;
  logic            s1_nz_b_r;

  pcm_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_accept),
    .wr_addr   (in_palette_addr),
    .wr_data   (in_palette_value),
    .rd_en     (pix_accept),
    .rd_addr_a (in_index_a),
    .rd_addr_b (in_index_b),
    .rd_data_a (pal_a),
    .rd_data_b (pal_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_nz_a_r <= (in_index_a != 8'd0);
      s1_nz_b_r <= (in_index_b != 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: screen colour select (backdrop, force, enable)
  // ---------------------------------------------------------------------------
  pcm_pkg::color_t col_a_nxt, col_b_nxt;
  pcm_pkg::color_t s2_col_a_r, s2_col_b_r;
  logic            s2_nz_a_r, s2_nz_b_r;

  always_comb begin
    if (!enable_a_r) begin
      col_a_nxt = '0;
    end else if (!s1_nz_a_r) begin
      col_a_nxt = backdrop_a_r;
    end else begin
      col_a_nxt = pal_a;
    end
    if (!enable_b_r) begin
      col_b_nxt = '0;
    end else if (!s1_nz_b_r || force_b_r) begin
      col_b_nxt = backdrop_b_r;
    end else begin
      col_b_nxt = pal_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_col_a_r <= col_a_nxt;
      s2_col_b_r <= col_b_nxt;
      s2_nz_a_r  <= s1_nz_a_r;
      s2_nz_b_r  <= s1_nz_b_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: blend or overlay, then encode into the output register
  // ---------------------------------------------------------------------------
  pcm_pkg::color_t mix_col;
  pcm_pkg::color_t res_nxt;
  logic            halve;
  logic [15:0]     s3_pix_r;

  assign halve = (mode_r == pcm_pkg::MODE_HALF);

  assign mix_col = {
    pcm_pkg::mix_channel(s2_col_a_r[14:10], s2_col_b_r[14:10], subtract_r, halve),
    pcm_pkg::mix_channel(s2_col_a_r[9:5],   s2_col_b_r[9:5],   subtract_r, halve),
    pcm_pkg::mix_channel(s2_col_a_r[4:0],   s2_col_b_r[4:0],   subtract_r, halve)
  };

  // The raw index picks the overlay winner, whatever enable or force did
  always_comb begin
    case (mode_r) inside
      pcm_pkg::MODE_BLEND,
      pcm_pkg::MODE_HALF:     res_nxt = mix_col;
      pcm_pkg::MODE_B_OVER_A: res_nxt = s2_nz_b_r ? s2_col_b_r : s2_col_a_r;
      pcm_pkg::MODE_A_OVER_B: res_nxt = s2_nz_a_r ? s2_col_a_r : s2_col_b_r;
      default:                res_nxt = mix_col;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s2_v_r) begin
      s3_pix_r <= pcm_pkg::encode565(res_nxt);
    end
  end

  assign out_valid        = s3_v_r;
  assign out_pixel_rgb565 = s3_pix_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_accept |=> !s1_v_r)
    else $error("palette write entered the pixel pipeline");

  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pix_accept |=> s1_v_r)
    else $error("accepted pixel lost at stage 1");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s3_adv) |=> out_valid)
    else $error("stage 2 pixel did not reach the output register");

endmodule
